>>> design/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the path diversity selector.
// ----------------------------------------------------------------------------
package pds_pkg;

	// Default maximum number of links in one path.
	localparam int MAX_PATH_DEF = 32;

	// Fixed field widths of the stream items.
	localparam int WORD_W     = 64;
	localparam int ID_W       = 8;
	localparam int DIV_W      = 7;
	localparam int LEN_W      = 6;
	localparam int REQ_W      = 2;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 24;

	// Request codes carried in the input tuser.
	localparam logic [REQ_W-1:0] REQ_REF  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CAND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINAL
	} pds_state_t;

	// Control from the sequencer to the match unit.
	typedef struct packed {
		logic clear;
		logic cmp_en;
	} pds_match_ctl_t;

endpackage

>>> design/path_diversity_selector.sv
// ----------------------------------------------------------------------------
// path_diversity_selector
// Picks the candidate path whose links differ most from a stored reference.
//
// Channel  Dir  Contents
// s_axis   in   tdata {candidate_id, link_word}, tuser req_type, tlast last
// m_axis   out  tdata {overflow, best_length, best_diversity, best_id},
//               tuser set_empty
//
// A candidate link sweeps the reference memory through its single read port,
// one entry per cycle, then passes a drain state; the last link of a candidate
// adds a selection update state. There is no clearing pass after reset. The
// result register holds one transaction; only an end of set waits for it to
// drain, other input transactions go on meanwhile.
// ----------------------------------------------------------------------------
module path_diversity_selector #(
	parameter int MAX_PATH = pds_pkg::MAX_PATH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [63:0] link_word, [71:64] candidate_id
	input  logic [pds_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tlast,
	// [1:0] req_type
	input  logic [pds_pkg::REQ_W-1:0]      s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] best_id, [14:8] best_diversity, [20:15] best_length, [21] overflow
	output logic [pds_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] set_empty
	output logic                           m_axis_tuser
);

	localparam int AW = $clog2(MAX_PATH);
	localparam int CW = $clog2(MAX_PATH + 1);
	localparam int DW = CW + 1;

	pds_pkg::pds_state_t state_q, state_d;

	logic [CW-1:0]            ref_len_q, cand_len_q, chosen_len_q, scan_idx_q;
	logic                     ref_done_q, any_cand_q, ovf_q;
	logic [pds_pkg::ID_W-1:0] chosen_id_q;
	logic signed [DW-1:0]     chosen_div_q;

	logic [pds_pkg::WORD_W-1:0] word_q;
	logic [pds_pkg::ID_W-1:0]   id_q;
	logic                       last_q;

	logic          cmp_en_s1;
	logic [AW-1:0] cmp_idx_s1;

	logic                        out_valid_q;
	logic [pds_pkg::ID_W-1:0]    out_id_q;
	logic [pds_pkg::DIV_W-1:0]   out_div_q;
	logic [pds_pkg::LEN_W-1:0]   out_len_q;
	logic                        out_empty_q, out_ovf_q;

	logic                       acc, acc_ref, acc_cand, acc_end;
	logic [pds_pkg::WORD_W-1:0] in_word;
	logic [pds_pkg::ID_W-1:0]   in_id;
	logic [CW-1:0]              eff_len, matched_cnt;
	logic                       ref_room, cand_room, scan_last, out_free;
	logic                       rd_en, wr_en;
	logic [AW-1:0]              rd_addr;
	logic [pds_pkg::WORD_W-1:0] rd_data;
	pds_pkg::pds_match_ctl_t    mctl;
	logic signed [DW-1:0]       div;
	logic                       take;
	logic signed [31:0]         div_ext;
	logic [31:0]                chosen_len_ext, ref_len_ext;

	// Input unpacking and handshake decode.
	assign in_word  = s_axis_tdata[pds_pkg::WORD_W-1:0];
	assign in_id    = s_axis_tdata[pds_pkg::IN_DATA_W-1:pds_pkg::WORD_W];
	assign out_free = !out_valid_q || m_axis_tready;
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign acc_ref  = acc && (s_axis_tuser == pds_pkg::REQ_REF);
	assign acc_cand = acc && (s_axis_tuser == pds_pkg::REQ_CAND);
	assign acc_end  = acc && (s_axis_tuser == pds_pkg::REQ_END);

	// A reference link after a finished reference starts over at entry zero.
	assign eff_len   = ref_done_q ? '0 : ref_len_q;
	assign ref_room  = eff_len < CW'(MAX_PATH);
	assign cand_room = cand_len_q < CW'(MAX_PATH);
	assign scan_last = scan_idx_q == (ref_len_q - CW'(1));

	// Diversity of the finished candidate and the selection rule.
	assign div  = signed'({1'b0, ref_len_q}) - signed'({1'b0, matched_cnt});
	assign take = !any_cand_q || (div > chosen_div_q) ||
		((div == chosen_div_q) && (cand_len_q < chosen_len_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pds_pkg::ST_IDLE: begin
				if (acc_cand) begin
					if (cand_room && (ref_len_q != '0)) begin
						state_d = pds_pkg::ST_SCAN;
					end else if (s_axis_tlast) begin
						state_d = pds_pkg::ST_FINAL;
					end
				end
			end
			pds_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = pds_pkg::ST_DRAIN;
				end
			end
			pds_pkg::ST_DRAIN: begin
				state_d = last_q ? pds_pkg::ST_FINAL : pds_pkg::ST_IDLE;
			end
			pds_pkg::ST_FINAL: begin
				state_d = pds_pkg::ST_IDLE;
			end
			default: begin
				state_d = pds_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		s_axis_tready = (state_q == pds_pkg::ST_IDLE) &&
			((s_axis_tuser != pds_pkg::REQ_END) || out_free);
		rd_en         = (state_q == pds_pkg::ST_SCAN);
		rd_addr       = scan_idx_q[AW-1:0];
		wr_en         = acc_ref && ref_room;
		mctl.cmp_en   = cmp_en_s1;
		mctl.clear    = (acc_ref && ref_done_q) || acc_end ||
			(state_q == pds_pkg::ST_FINAL);
	end

	pds_ref_mem #(
		.DEPTH (MAX_PATH),
		.AW    (AW)
	) u_ref_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (eff_len[AW-1:0]),
		.wr_data (in_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pds_match #(
		.MAX_PATH (MAX_PATH),
		.AW       (AW),
		.CW       (CW)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (mctl),
		.cmp_idx     (cmp_idx_s1),
		.ref_word    (rd_data),
		.cand_word   (word_q),
		.matched_cnt (matched_cnt)
	);

	// State register and read pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pds_pkg::ST_IDLE;
			cmp_en_s1  <= 1'b0;
			cmp_idx_s1 <= '0;
			scan_idx_q <= '0;
		end else begin
			state_q    <= state_d;
			cmp_en_s1  <= rd_en;
			cmp_idx_s1 <= rd_addr;
			if (acc_cand) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
		end
	end

	// Reference, candidate and selection state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q    <= '0;
			ref_done_q   <= 1'b0;
			cand_len_q   <= '0;
			chosen_id_q  <= '0;
			chosen_div_q <= '1;
			chosen_len_q <= '1;
			any_cand_q   <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			if (acc_ref) begin
				if (ref_done_q) begin
					cand_len_q   <= '0;
					chosen_id_q  <= '0;
					chosen_div_q <= '1;
					chosen_len_q <= '1;
					any_cand_q   <= 1'b0;
				end
				ref_len_q  <= ref_room ? (eff_len + CW'(1)) : eff_len;
				ovf_q      <= (ref_done_q ? 1'b0 : ovf_q) | !ref_room;
				ref_done_q <= s_axis_tlast;
			end else if (acc_cand) begin
				ref_done_q <= 1'b1;
				if (cand_room) begin
					cand_len_q <= cand_len_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (acc_end) begin
				cand_len_q   <= '0;
				chosen_id_q  <= '0;
				chosen_div_q <= '1;
				chosen_len_q <= '1;
				any_cand_q   <= 1'b0;
				ovf_q        <= 1'b0;
			end else if (state_q == pds_pkg::ST_FINAL) begin
				if (take) begin
					chosen_id_q  <= id_q;
					chosen_div_q <= div;
					chosen_len_q <= cand_len_q;
				end
				any_cand_q <= 1'b1;
				cand_len_q <= '0;
			end
		end
	end

	// Candidate link held for the sweep.
	always_ff @(posedge clk) begin
		if (acc_cand) begin
			word_q <= in_word;
			id_q   <= in_id;
			last_q <= s_axis_tlast;
		end
	end

	// Result fields resized to the port widths.
	assign div_ext        = 32'(chosen_div_q);
	assign chosen_len_ext = 32'(chosen_len_q);
	assign ref_len_ext    = 32'(ref_len_q);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_end) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_end) begin
			out_ovf_q <= ovf_q;
			if (any_cand_q) begin
				out_id_q    <= chosen_id_q;
				out_div_q   <= div_ext[pds_pkg::DIV_W-1:0];
				out_len_q   <= chosen_len_ext[pds_pkg::LEN_W-1:0];
				out_empty_q <= 1'b0;
			end else begin
				out_id_q    <= '0;
				out_div_q   <= '1;
				out_len_q   <= ref_len_ext[pds_pkg::LEN_W-1:0];
				out_empty_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_ovf_q, out_len_q, out_div_q, out_id_q};
	assign m_axis_tuser  = out_empty_q;

	// Compares only follow a read issued during the sweep.
	a_cmp_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_en_s1 |-> (state_q == pds_pkg::ST_SCAN || state_q == pds_pkg::ST_DRAIN))
		else $error("compare outside of a reference sweep");

	// The reference length never passes the store depth.
	a_ref_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ref_len_q <= CW'(MAX_PATH))
		else $error("reference length beyond store depth");

	// A selection update is followed directly by idle.
	a_final_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pds_pkg::ST_FINAL) |=> (state_q == pds_pkg::ST_IDLE))
		else $error("selection update did not return to idle");

	// An end of set is taken only when the result register can hold it.
	a_end_room: assert property (@(posedge clk) disable iff (!arst_n)
		acc_end |-> (!out_valid_q || m_axis_tready))
		else $error("end of set accepted over a pending result");

endmodule

>>> design/pds_ref_mem.sv
// ----------------------------------------------------------------------------
// pds_ref_mem
// Reference link store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pds_ref_mem #(
	parameter int DEPTH = pds_pkg::MAX_PATH_DEF,
	parameter int AW    = $clog2(pds_pkg::MAX_PATH_DEF)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [pds_pkg::WORD_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [pds_pkg::WORD_W-1:0] rd_data
);

	logic [pds_pkg::WORD_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/pds_match.sv
// ----------------------------------------------------------------------------
// pds_match
// Match unit: compares stored reference links with the current candidate
// link, keeps one matched flag per reference entry and a count of them.
// ----------------------------------------------------------------------------
module pds_match #(
	parameter int MAX_PATH = pds_pkg::MAX_PATH_DEF,
	parameter int AW       = $clog2(pds_pkg::MAX_PATH_DEF),
	parameter int CW       = $clog2(pds_pkg::MAX_PATH_DEF + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pds_pkg::pds_match_ctl_t    ctl,
	input  logic [AW-1:0]              cmp_idx,
	input  logic [pds_pkg::WORD_W-1:0] ref_word,
	input  logic [pds_pkg::WORD_W-1:0] cand_word,
	output logic [CW-1:0]              matched_cnt
);

	logic [MAX_PATH-1:0] mask_q;
	logic [CW-1:0]       cnt_q;
	logic                hit;

	// A reference entry counts once, however many candidate links match it.
	assign hit = ctl.cmp_en && (ref_word == cand_word) && !mask_q[cmp_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.clear) begin
			mask_q <= '0;
			cnt_q  <= '0;
		end else if (hit) begin
			mask_q[cmp_idx] <= 1'b1;
			cnt_q           <= cnt_q + CW'(1);
		end
	end

	assign matched_cnt = cnt_q;

endmodule

>>> test/path_diversity_selector_tb.sv
// ----------------------------------------------------------------------------
// path_diversity_selector_tb
// Self-checking testbench of the path diversity selector. Reference and
// candidate paths stream in on s_axis, and a scoreboard predicts every
// end-of-set selection and checks it against each m_axis transaction.
// The stimulus starts with directed sets (ties, duplicates, empty sets,
// unfinished candidates and a reference restart), then continues with random
// sets, broken sequences and noise. Both sides idle at random, the receiver
// holds off once long enough to stall the input, and the sender pauses until
// the output has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected contents of one output transaction.
typedef struct {
	logic [pds_pkg::ID_W-1:0]  id;
	logic [pds_pkg::DIV_W-1:0] diversity;
	logic [pds_pkg::LEN_W-1:0] length;
	bit                        empty;
	bit                        overflow;
} selection_t;

// Tracks reference and candidates, and checks the reported selections.
class diversity_scoreboard;
	localparam int MAXP = pds_pkg::MAX_PATH_DEF;

	logic [63:0]               ref_links [MAXP];
	int unsigned               ref_len;
	bit                        ref_done;
	bit                        match_mask [MAXP];
	int unsigned               cand_len;
	logic [pds_pkg::ID_W-1:0]  chosen_id;
	int                        chosen_div;
	int unsigned               chosen_len;
	bit                        any_cand;
	bit                        ovf_seen;
	selection_t                expected_picks [$];
	int                        errors;
	int                        picks_checked;
	int                        empty_picks;
	int                        overflow_picks;

	function new();
		ref_len = 0;
		ref_done = 0;
		ovf_seen = 0;
		errors = 0;
		picks_checked = 0;
		empty_picks = 0;
		overflow_picks = 0;
		clear_candidate();
		clear_selection();
	endfunction

	function void clear_candidate();
		foreach (match_mask[i]) match_mask[i] = 0;
		cand_len = 0;
	endfunction

	function void clear_selection();
		chosen_id = '0;
		chosen_div = -1;
		chosen_len = 32'hFFFF_FFFF;
		any_cand = 0;
	endfunction

	function int pending();
		return expected_picks.size();
	endfunction

	// Prints one line per mismatch and counts it.
	task report(string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	// Advances the predicted state by one accepted input transaction.
	function void take_item(logic [1:0] req, logic [63:0] word, bit last,
			logic [7:0] id);
		int         div;
		selection_t pick;
		case (req)
			pds_pkg::REQ_REF: begin
				// A reference link after a finished reference starts over.
				if (ref_done) begin
					ref_len = 0;
					ref_done = 0;
					clear_candidate();
					clear_selection();
					ovf_seen = 0;
				end
				if (ref_len < MAXP) begin
					ref_links[ref_len] = word;
					ref_len++;
				end else begin
					ovf_seen = 1;
				end
				if (last)
					ref_done = 1;
			end
			pds_pkg::REQ_CAND: begin
				ref_done = 1;
				if (cand_len < MAXP) begin
					for (int i = 0; i < ref_len; i++)
						if (ref_links[i] == word)
							match_mask[i] = 1;
					cand_len++;
				end else begin
					ovf_seen = 1;
				end
				// On the last link, score the candidate and update the choice.
				if (last) begin
					div = 0;
					for (int i = 0; i < ref_len; i++)
						if (!match_mask[i])
							div++;
					if (!any_cand || div > chosen_div ||
							(div == chosen_div && cand_len < chosen_len)) begin
						chosen_id = id;
						chosen_div = div;
						chosen_len = cand_len;
					end
					any_cand = 1;
					clear_candidate();
				end
			end
			pds_pkg::REQ_END: begin
				if (any_cand) begin
					pick.id = chosen_id;
					pick.diversity = chosen_div[6:0];
					pick.length = chosen_len[5:0];
					pick.empty = 0;
				end else begin
					pick.id = '0;
					pick.diversity = '1;
					pick.length = ref_len[5:0];
					pick.empty = 1;
				end
				pick.overflow = ovf_seen;
				expected_picks.insert(expected_picks.size(), pick);
				clear_candidate();
				clear_selection();
				ovf_seen = 0;
			end
			default: ;
		endcase
	endfunction

	// Compares one output transaction with the oldest expected selection.
	task check_selection(logic [pds_pkg::OUT_DATA_W-1:0] data,
			logic set_empty);
		selection_t pick;
		if (expected_picks.size() == 0) begin
			report($sformatf("unexpected result tdata=%h tuser=%b", data, set_empty));
			return;
		end
		pick = expected_picks.pop_front();
		picks_checked++;
		if (pick.empty)
			empty_picks++;
		if (pick.overflow)
			overflow_picks++;
		if (data[7:0] !== pick.id)
			report($sformatf("best_id %h, expected %h", data[7:0], pick.id));
		if (data[14:8] !== pick.diversity)
			report($sformatf("best_diversity %h, expected %h", data[14:8],
				pick.diversity));
		if (data[20:15] !== pick.length)
			report($sformatf("best_length %0d, expected %0d", data[20:15],
				pick.length));
		if (data[21] !== pick.overflow)
			report($sformatf("overflow %b, expected %b", data[21], pick.overflow));
		if (data[23:22] !== 2'b00)
			report($sformatf("tdata padding %b, expected 00", data[23:22]));
		if (set_empty !== pick.empty)
			report($sformatf("set_empty %b, expected %b", set_empty, pick.empty));
	endtask
endclass

module path_diversity_selector_tb;

	// Request code that the block ignores.
	localparam logic [pds_pkg::REQ_W-1:0] REQ_NONE = 2'd3;
	localparam int                        MAXP     = pds_pkg::MAX_PATH_DEF;
	localparam int                        HOLD_CYC = 300;
	localparam int                        N_ITEMS  = 1250;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [pds_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                           s_axis_tlast;
	logic [pds_pkg::REQ_W-1:0]      s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [pds_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tuser;

	diversity_scoreboard picks = new();

	bit          no_idle;
	bit          hold_request;
	int          items_sent;
	int          sets_sent;
	logic [63:0] word_pool [8];
	logic [63:0] ref_words [$];

	path_diversity_selector #(
		.MAX_PATH(MAXP)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#2000000;
		$display("[path_diversity_selector] ERROR");
		$finish;
	end

	// Draws a link word: extremes, a small shared pool, or fully random.
	function automatic logic [63:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		if (r < 45)
			return word_pool[$urandom_range(0, 7)];
		return {$urandom(), $urandom()};
	endfunction

	// Offers one input transaction after a random gap and waits for acceptance.
	task automatic send_link(logic [1:0] req, logic [63:0] word, bit last,
			logic [7:0] id);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {id, word};
		s_axis_tlast <= last;
		s_axis_tuser <= req;
		do @(posedge clk); while (!s_axis_tready);
		picks.take_item(req, word, last, id);
		if (req != REQ_NONE)
			items_sent++;
		if (req == pds_pkg::REQ_END)
			sets_sent++;
	endtask

	task automatic send_end();
		send_link(pds_pkg::REQ_END, {$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	// Sends a reference of the given length; the last link is flagged on request.
	task automatic send_reference(int len, bit finish);
		logic [63:0] w;
		ref_words.delete();
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 5) == 0)
				w = ref_words[$urandom_range(0, ref_words.size() - 1)];
			else
				w = pick_word();
			ref_words.insert(ref_words.size(), w);
			send_link(pds_pkg::REQ_REF, w, finish && (i == len - 1),
				8'($urandom_range(0, 255)));
		end
	endtask

	// Sends a candidate whose links partly come from the current reference.
	task automatic send_candidate(int len, bit finish);
		logic [63:0] w;
		for (int i = 0; i < len; i++) begin
			if (ref_words.size() > 0 && $urandom_range(0, 1))
				w = ref_words[$urandom_range(0, ref_words.size() - 1)];
			else
				w = pick_word();
			send_link(pds_pkg::REQ_CAND, w, finish && (i == len - 1),
				8'($urandom_range(0, 255)));
		end
	endtask

	// Stops offering until every expected result has come out.
	task automatic wait_for_picks();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (picks.pending() > 0) @(negedge clk);
		repeat (2 * (MAXP + 3)) @(negedge clk);
	endtask

	// Receiver: random stall before each result, with one long hold-off on request.
	initial begin
		int k;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			k = no_idle ? 0 : $urandom_range(0, 7);
			if (hold_request) begin
				hold_request = 0;
				k = HOLD_CYC;
			end
			@(negedge clk);
			if (k > 0) begin
				m_axis_tready <= 1'b0;
				repeat (k) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			picks.check_selection(m_axis_tdata, m_axis_tuser);
		end
	end

	// Reset, directed sets, random sets and end of run.
	initial begin
		int len;
		int ncand;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = pds_pkg::REQ_REF;
		arst_n = 1'b0;
		no_idle = 0;
		hold_request = 0;
		items_sent = 0;
		sets_sent = 0;
		foreach (word_pool[i]) word_pool[i] = {$urandom(), $urandom()};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Empty set before any reference, and an ignored request code.
		send_end();
		send_link(REQ_NONE, '1, 1'b1, 8'hFF);

		// Reference with extreme words and a duplicate link.
		send_link(pds_pkg::REQ_REF, '0, 1'b0, 8'h00);
		send_link(pds_pkg::REQ_REF, '1, 1'b0, 8'hFF);
		send_link(pds_pkg::REQ_REF, '0, 1'b0, 8'h5A);
		send_link(pds_pkg::REQ_REF, 64'h5, 1'b1, 8'hA5);

		// Scoring, ties on diversity and on length.
		send_link(pds_pkg::REQ_CAND, '1, 1'b1, 8'hFF);
		send_link(pds_pkg::REQ_CAND, '0, 1'b1, 8'h00);
		send_link(pds_pkg::REQ_CAND, 64'h7, 1'b1, 8'h11);
		send_link(pds_pkg::REQ_CAND, 64'h8, 1'b0, 8'h99);
		send_link(pds_pkg::REQ_CAND, 64'h9, 1'b1, 8'h22);
		send_link(pds_pkg::REQ_CAND, 64'h9, 1'b1, 8'h33);
		send_end();

		// An unfinished candidate is dropped at the end of the set.
		send_link(pds_pkg::REQ_CAND, '0, 1'b0, 8'h01);
		send_end();

		// New reference, candidate before its end, then another restart.
		send_link(pds_pkg::REQ_REF, 64'hA, 1'b0, 8'h02);
		send_link(pds_pkg::REQ_CAND, 64'hB, 1'b1, 8'h44);
		send_link(pds_pkg::REQ_REF, 64'hC, 1'b1, 8'h03);
		send_end();

		// Long receiver hold-off while ends keep coming, so the input stalls.
		hold_request = 1;
		repeat (4) send_end();
		wait_for_picks();

		// Random part: mostly well-formed sets, some broken sequences and noise.
		while (items_sent < N_ITEMS) begin
			no_idle = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 9) < 6) begin
					len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
						: $urandom_range(28, 36);
					send_reference(len, 1'b1);
				end
				ncand = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
				for (int c = 0; c < ncand; c++) begin
					len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10)
						: $urandom_range(28, 35);
					send_candidate(len, 1'b1);
				end
				send_end();
			end else begin
				case ($urandom_range(0, 5))
					0: send_link(REQ_NONE, {$urandom(), $urandom()},
						1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
					1: send_end();
					2: begin
						send_candidate($urandom_range(1, 5), 1'b0);
						send_end();
					end
					3: begin
						send_reference($urandom_range(1, 5), 1'b0);
						send_candidate($urandom_range(1, 4), 1'b1);
						send_end();
					end
					4: begin
						send_candidate($urandom_range(1, 4), 1'b1);
						send_reference($urandom_range(1, 3), 1'($urandom_range(0, 1)));
						send_end();
					end
					default: begin
						repeat (3)
							send_link(2'($urandom_range(0, 3)), pick_word(),
								1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
					end
				endcase
			end
			if ($urandom_range(0, 29) == 0)
				wait_for_picks();
		end
		no_idle = 0;

		// Drain and report.
		wait_for_picks();
		$display("Sent %0d transactions in %0d sets; %0d results checked.",
			items_sent, sets_sent, picks.picks_checked);
		$display("Of these, %0d were empty sets and %0d flagged overflow.",
			picks.empty_picks, picks.overflow_picks);
		if (picks.errors == 0 && picks.pending() == 0) begin
			$display("[path_diversity_selector] OK");
		end else begin
			$display("[path_diversity_selector] ERROR");
		end
		$finish;
	end

endmodule
